// ----- rtl/wsa_pkg.sv -----
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared sizes, codes, token type and ID helper for the worker slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package wsa_pkg;

  localparam int SLOT_COUNT   = 64;
  localparam int DYNAMIC_BASE = 16;
  localparam int LOCAL_BITS   = 8;

  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CELL_W     = 4;
  localparam int CELL_SLOTS = 1 << CELL_W;
  localparam int CELL_COUNT = (SLOT_COUNT + CELL_SLOTS - 1) / CELL_SLOTS;
  localparam int CIDX_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  localparam int REQ_W    = 3;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 3;
  localparam int STATE_W  = 2;
  localparam int NODE_W   = 8;
  localparam int PADDR_W  = 3;

  localparam logic [ID_W-1:0] LOCAL_MASK = ID_W'((32'd1 << LOCAL_BITS) - 32'd1);

  localparam logic [PADDR_W-3:0] REG_NODE_ID = '0;

  localparam logic [REQ_W-1:0] REQ_DYN       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_STATIC    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ACTIVATE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TERMINATE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_QUERY     = 3'd5;

  localparam logic [STATUS_W-1:0] RS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] RS_NO_FREE   = 3'd1;
  localparam logic [STATUS_W-1:0] RS_RANGE     = 3'd2;
  localparam logic [STATUS_W-1:0] RS_IN_DYN    = 3'd3;
  localparam logic [STATUS_W-1:0] RS_BUSY      = 3'd4;
  localparam logic [STATUS_W-1:0] RS_BAD_STATE = 3'd5;

  localparam logic [STATE_W-1:0] ST_INACTIVE    = 2'd0;
  localparam logic [STATE_W-1:0] ST_DEPLOYING   = 2'd1;
  localparam logic [STATE_W-1:0] ST_ACTIVE      = 2'd2;
  localparam logic [STATE_W-1:0] ST_TERMINATING = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [REQ_W-1:0]    op;
    logic [SLOT_W-1:0]   slot;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [STATE_W-1:0]  state;
  } wsa_tok_t;

  function automatic logic [ID_W-1:0] wsa_gid(input logic [NODE_W-1:0] node,
                                               input logic [31:0] loc_v);
    logic [31:0] hi;
    hi = {{(32-NODE_W){1'b0}}, node} << LOCAL_BITS;
    return (hi[ID_W-1:0] & ~LOCAL_MASK) | (loc_v[ID_W-1:0] & LOCAL_MASK);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/wsa_if.sv -----
// ----------------------------------------------------------------------------
// wsa_if
// Request and response channels of the worker slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsa_req_if;
  import wsa_pkg::*;
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [ID_W-1:0]     worker_id;
  modport source (output valid, req_type, worker_id, input ready);
  modport sink   (input valid, req_type, worker_id, output ready);
endinterface

interface wsa_rsp_if;
  import wsa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     assigned_id;
  logic [STATE_W-1:0]  slot_state;
  modport source (output valid, status, assigned_id, slot_state, input ready);
  modport sink   (input valid, status, assigned_id, slot_state, output ready);
endinterface

`default_nettype wire

// ----- rtl/wsa_cell.sv -----
// ----------------------------------------------------------------------------
// wsa_cell
// One cell of the slot chain: holds a group of slot states, applies the
// passing request token to its own slots and hands the token on.
// ----------------------------------------------------------------------------
`default_nettype none

module wsa_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [wsa_pkg::CIDX_W-1:0] cell_idx_i,
  input  wsa_pkg::wsa_tok_t         tok_i,
  output wsa_pkg::wsa_tok_t         tok_o
);
  import wsa_pkg::*;

  logic [STATE_W-1:0] st_q [CELL_SLOTS];
  logic [STATE_W-1:0] st_d [CELL_SLOTS];
  wsa_tok_t           tok_q;
  wsa_tok_t           tok_d;

  logic [31:0]           base;
  logic [31:0]           slot_ext;
  logic [31:0]           off;
  logic                  own;
  logic [CELL_W-1:0]     sel;
  logic [STATE_W-1:0]    cur;
  logic [CELL_SLOTS-1:0] elig;
  logic                  found;
  logic [CELL_W-1:0]     first;

  assign base     = {{(32-CIDX_W){1'b0}}, cell_idx_i} << CELL_W;
  assign slot_ext = {{(32-SLOT_W){1'b0}}, tok_i.slot};
  assign off      = slot_ext - base;
  assign own      = (slot_ext >= base) && (slot_ext < base + 32'(CELL_SLOTS));
  assign sel      = off[CELL_W-1:0];
  assign cur      = st_q[sel];

  // free slots of this cell inside the dynamic range, lowest one wins
  always_comb begin
    found = 1'b0;
    first = '0;
    for (int j = 0; j < CELL_SLOTS; j++) begin
      elig[j] = (base + 32'(j) >= 32'(DYNAMIC_BASE)) &&
                (base + 32'(j) < 32'(SLOT_COUNT)) && (st_q[j] == ST_INACTIVE);
    end
    for (int j = CELL_SLOTS - 1; j >= 0; j--) begin
      if (elig[j]) begin
        found = 1'b1;
        first = CELL_W'(j);
      end
    end
  end

  always_comb begin
    st_d  = st_q;
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.done) begin
      if (tok_i.op == REQ_DYN) begin
        if (found) begin
          st_d[first]  = ST_DEPLOYING;
          tok_d.done   = 1'b1;
          tok_d.slot   = SLOT_W'(base + {{(32-CELL_W){1'b0}}, first});
          tok_d.status = RS_OK;
          tok_d.state  = ST_DEPLOYING;
        end
      end else if (own) begin
        tok_d.done   = 1'b1;
        tok_d.status = RS_OK;
        tok_d.state  = cur;
        case (tok_i.op)
          REQ_STATIC: begin
            if (slot_ext >= 32'(DYNAMIC_BASE)) begin
              tok_d.status = RS_IN_DYN;
            end else if (cur != ST_INACTIVE) begin
              tok_d.status = RS_BUSY;
            end else begin
              tok_d.state = ST_DEPLOYING;
            end
          end
          REQ_RELEASE: begin
            if (cur == ST_ACTIVE) begin
              tok_d.status = RS_BAD_STATE;
            end else begin
              tok_d.state = ST_INACTIVE;
            end
          end
          REQ_ACTIVATE: begin
            if (cur != ST_DEPLOYING) begin
              tok_d.status = RS_BAD_STATE;
            end else begin
              tok_d.state = ST_ACTIVE;
            end
          end
          REQ_TERMINATE: begin
            if (cur != ST_ACTIVE) begin
              tok_d.status = RS_BAD_STATE;
            end else begin
              tok_d.state = ST_TERMINATING;
            end
          end
          REQ_QUERY: begin
            tok_d.status = RS_OK;
          end
          default: begin
            tok_d.status = RS_BAD_STATE;
          end
        endcase
        st_d[sel] = tok_d.state;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '{default: ST_INACTIVE};
      tok_q <= '0;
    end else begin
      st_q  <= st_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ----- rtl/worker_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// worker_slot_allocator
// Lifecycle table of worker slots with dynamic and static reservation.
//
// Requests come in on req_i (req_type, worker_id) and each gives exactly one
// response on rsp_o (status, assigned_id, slot_state); a transfer happens on
// a clock edge with valid and ready both high. node_id is written over the
// APB port at byte address 0; the user must write it only while no request
// is in flight, which the block does not enforce. The slot states live in a
// chain of CELL_COUNT cells of 16 slots each (4 cells for 64 slots). A
// request travels the chain as a token, one cell per cycle, and the cell
// owning the slot (or, for a dynamic reserve, the first cell with a free
// slot) updates it. A token runs from the launch register through the
// cells to the output register; a slot out of range skips the chain and
// goes via the holding register. One request is in flight at a time: the
// next is taken once the previous result is in the output register.
// The response sits in an output register; while the receiver stalls, the
// next request is still taken, and its result waits in a holding register.
// Reset leaves every slot inactive and node_id at 0.
// ----------------------------------------------------------------------------
`default_nettype none

module worker_slot_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wsa_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  wsa_req_if.sink                     req_i,
  wsa_rsp_if.source                   rsp_o
);
  import wsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_WAIT = 3'b100
  } fsm_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [STATE_W-1:0]  state;
  } wsa_res_t;

  fsm_e               fsm_q, fsm_d;
  logic [NODE_W-1:0]  node_q;
  wsa_tok_t           launch_q, launch_d;
  wsa_res_t           pend_q, pend_d;
  wsa_res_t           res_q, res_d;
  logic               rsp_valid_q, rsp_valid_d;

  wsa_tok_t           chain [CELL_COUNT+1];
  wsa_tok_t           tail;
  wsa_res_t           chain_res;
  wsa_res_t           bypass_res;
  logic [ID_W-1:0]    loc16;
  logic               acc;
  logic               oor;
  logic               out_free;
  logic               cfg_hit;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[PADDR_W-1:2] == REG_NODE_ID);
  assign prdata  = cfg_hit ? {{(32-NODE_W){1'b0}}, node_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q <= '0;
    end else if (psel && penable && pwrite && cfg_hit) begin
      node_q <= pwdata[NODE_W-1:0];
    end
  end

  // cell chain
  assign chain[0] = launch_q;

  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    wsa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CIDX_W'(k)),
      .tok_i      (chain[k]),
      .tok_o      (chain[k+1])
    );
  end

  assign tail = chain[CELL_COUNT];

  always_comb begin
    if (tail.op == REQ_DYN && !tail.done) begin
      chain_res.status = RS_NO_FREE;
      chain_res.id     = '0;
      chain_res.state  = ST_INACTIVE;
    end else begin
      chain_res.status = tail.status;
      chain_res.id     = wsa_gid(node_q, {{(32-SLOT_W){1'b0}}, tail.slot});
      chain_res.state  = tail.state;
    end
  end

  // request side
  assign req_i.ready = (fsm_q == S_IDLE);
  assign acc         = req_i.valid && req_i.ready;
  assign loc16       = req_i.worker_id & LOCAL_MASK;
  assign oor         = (req_i.req_type != REQ_DYN) &&
                       ({{(32-ID_W){1'b0}}, loc16} >= 32'(SLOT_COUNT));
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    bypass_res.status = (req_i.req_type > REQ_QUERY) ? RS_BAD_STATE : RS_RANGE;
    bypass_res.id     = wsa_gid(node_q, {{(32-ID_W){1'b0}}, loc16});
    bypass_res.state  = ST_INACTIVE;
  end

  always_comb begin
    fsm_d          = fsm_q;
    pend_d         = pend_q;
    res_d          = res_q;
    rsp_valid_d    = rsp_valid_q && !rsp_o.ready;
    launch_d       = '0;
    launch_d.op    = req_i.req_type;
    launch_d.slot  = SLOT_W'({{(32-ID_W){1'b0}}, loc16});
    launch_d.valid = 1'b0;
    case (fsm_q)
      S_IDLE: begin
        if (acc) begin
          if (oor) begin
            pend_d = bypass_res;
            fsm_d  = S_WAIT;
          end else begin
            launch_d.valid = 1'b1;
            fsm_d          = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (tail.valid) begin
          if (out_free) begin
            res_d       = chain_res;
            rsp_valid_d = 1'b1;
            fsm_d       = S_IDLE;
          end else begin
            pend_d = chain_res;
            fsm_d  = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (out_free) begin
          res_d       = pend_q;
          rsp_valid_d = 1'b1;
          fsm_d       = S_IDLE;
        end
      end
      default: begin
        fsm_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      launch_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      launch_q    <= launch_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  // response side
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = res_q.status;
  assign rsp_o.assigned_id = res_q.id;
  assign rsp_o.slot_state  = res_q.state;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> !req_i.ready)
    else $error("request taken while a request is in flight");

  a_tail_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> (fsm_q == S_RUN))
    else $error("token left the chain outside the run state");

  a_launch_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q.valid |-> (fsm_q == S_RUN))
    else $error("token launched outside the run state");

  a_no_free_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && res_q.status == RS_NO_FREE) |->
      (res_q.id == '0 && res_q.state == ST_INACTIVE))
    else $error("no-free response carries a slot");
`endif

endmodule

`default_nettype wire
